[rtl/iptp_pkg.sv]
// Shared types and constants for the IPv6 text address parser.
// Holds the classified character item, the result record and the fixed sizes.
// No dependencies.
`timescale 1ns / 1ps

package iptp_pkg;

  // Address geometry.
  localparam int NUM_GROUPS   = 8;
  localparam int GROUP_W      = 16;
  localparam int MAX_DIGITS   = 4;
  localparam int CNT_W        = 4;
  localparam int DIGIT_CNT_W  = 3;
  localparam int CHAR_W       = 8;
  localparam int NIBBLE_W     = 4;
  localparam logic [CHAR_W-1:0] COLON_CHAR = 8'h3A;

  // Character classes as decided by the front part.
  typedef enum logic [1:0] {
    CLS_COLON = 2'd0,
    CLS_HEX   = 2'd1,
    CLS_OTHER = 2'd2
  } char_cls_t;

  typedef logic [GROUP_W-1:0] group_t;

  // One classified character on its way from the front to the back.
  typedef struct packed {
    char_cls_t           cls;
    logic [NIBBLE_W-1:0] nibble;
    logic                last;
  } char_item_t;

  // One finished address.
  typedef struct packed {
    logic                         valid;
    group_t [NUM_GROUPS-1:0]      grp;
  } result_t;

  // Handshake status of the queue toward the back part.
  typedef struct packed {
    logic valid;
    logic full;
  } queue_stat_t;

endpackage

[rtl/ipv6_text_address_parser_unit.sv]
// Top level of the IPv6 text address parser.
// Connects the classifying front part, the character queue and the parse back part.
// Depends on iptp_pkg, iptp_front, iptp_queue and iptp_back.
//
// Usage: the address text enters one character per transfer on the input
// channel (push/full), with in_last marking the final character. Each final
// character yields one result on the output channel (empty/pop): a valid bit
// and the eight expanded 16-bit groups, all zero when the text is malformed.
// Throughput is one character per cycle while no final character waits; the
// back part consumes one queued character each cycle under that condition.
// A result appears (empty low) once the final character has left the queue
// and loaded the result register; characters ahead of it delay it. The
// result register holds one address: while it waits untaken, characters of
// the next address keep flowing, and only the next final character waits in
// the queue; once the queue fills, full rises. Synchronous reset clears the
// queue, the parse state and the result full flag; no clearing pass is needed.
`timescale 1ns / 1ps

module ipv6_text_address_parser_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_character,
  input  logic        in_last,
  output logic        empty,
  input  logic        pop,
  output logic        out_valid_res,
  output logic [15:0] out_group_0,
  output logic [15:0] out_group_1,
  output logic [15:0] out_group_2,
  output logic [15:0] out_group_3,
  output logic [15:0] out_group_4,
  output logic [15:0] out_group_5,
  output logic [15:0] out_group_6,
  output logic [15:0] out_group_7
);

  iptp_pkg::char_item_t  front_item;
  iptp_pkg::char_item_t  q_item;
  iptp_pkg::queue_stat_t q_stat;
  logic                  q_take;
  iptp_pkg::result_t     res;

  iptp_front u_front (
    .in_character (in_character),
    .in_last      (in_last),
    .item         (front_item)
  );

  iptp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_item (front_item),
    .rd_en   (q_take),
    .rd_item (q_item),
    .stat    (q_stat)
  );

  iptp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_stat.valid),
    .q_item  (q_item),
    .q_take  (q_take),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  // Result fields; group 0 is the most significant.
  assign full          = q_stat.full;
  assign out_valid_res = res.valid;
  assign out_group_0   = res.grp[7];
  assign out_group_1   = res.grp[6];
  assign out_group_2   = res.grp[5];
  assign out_group_3   = res.grp[4];
  assign out_group_4   = res.grp[3];
  assign out_group_5   = res.grp[2];
  assign out_group_6   = res.grp[1];
  assign out_group_7   = res.grp[0];

endmodule

[rtl/iptp_front.sv]
// Front part of the IPv6 text address parser: classifies each incoming
// character as colon, hex digit or other and extracts the digit value.
// Depends on iptp_pkg.
`timescale 1ns / 1ps

module iptp_front (
  input  logic [iptp_pkg::CHAR_W-1:0] in_character,
  input  logic                        in_last,
  output iptp_pkg::char_item_t        item
);

  // Decode one ASCII character.
  always_comb begin
    item.last   = in_last;
    item.nibble = '0;
    item.cls    = iptp_pkg::CLS_OTHER;
    if (in_character == iptp_pkg::COLON_CHAR) begin
      item.cls = iptp_pkg::CLS_COLON;
    end else if (in_character inside {[8'h30:8'h39]}) begin
      item.cls    = iptp_pkg::CLS_HEX;
      item.nibble = in_character[3:0];
    end else if (in_character inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      // Letters a-f and A-F share their low three bits: 1..6 maps to 10..15.
      item.cls    = iptp_pkg::CLS_HEX;
      item.nibble = 4'(in_character[2:0] + 4'd9);
    end
  end

endmodule

[rtl/iptp_queue.sv]
// Short queue of classified characters between the front and back parts.
// Flip-flop storage with a fill count; depth set by a parameter (two or more).
// Depends on iptp_pkg.
`timescale 1ns / 1ps

module iptp_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  iptp_pkg::char_item_t  wr_item,
  input  logic                  rd_en,
  output iptp_pkg::char_item_t  rd_item,
  output iptp_pkg::queue_stat_t stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

  iptp_pkg::char_item_t slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              do_wr, do_rd;

  assign stat.valid = (fill_r != '0);
  assign stat.full  = (fill_r == FULL_FILL);
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && stat.valid;
  assign rd_item    = slot_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (do_wr && !do_rd) begin
      fill_nxt = FILL_W'(fill_r + 1'b1);
    end else if (do_rd && !do_wr) begin
      fill_nxt = FILL_W'(fill_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Slot storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

  // The fill count never passes the depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_FILL)
    else $error("queue fill count beyond depth");

  // A transfer in without a transfer out grows the fill by one.
  a_fill_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> (fill_r == FILL_W'($past(fill_r) + 1'b1)))
    else $error("queue fill count did not grow on write");

  // Read and write pointers meet only when the queue is empty or full.
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r == rd_ptr_r) |-> (fill_r == '0 || fill_r == FULL_FILL))
    else $error("queue pointers disagree with fill count");

endmodule

[rtl/iptp_back.sv]
// Back part of the IPv6 text address parser: runs the per-character parse
// state, collects groups before and after the "::" gap, and holds the result.
// Depends on iptp_pkg.
`timescale 1ns / 1ps

module iptp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  iptp_pkg::char_item_t q_item,
  output logic                 q_take,
  input  logic                 pop,
  output logic                 empty,
  output iptp_pkg::result_t    res
);

  localparam int NG = iptp_pkg::NUM_GROUPS;
  localparam int CW = iptp_pkg::CNT_W;
  localparam int DW = iptp_pkg::DIGIT_CNT_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(NG);
  localparam logic [DW-1:0] MAX_DIG  = DW'(iptp_pkg::MAX_DIGITS);

  // Parse state.
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   gap_r, gap_nxt;
  logic [CW-1:0]          gidx_r, gidx_nxt;
  iptp_pkg::group_t       acc_r, acc_nxt;
  logic [DW-1:0]          dcnt_r, dcnt_nxt;
  logic                   pcol_r, pcol_nxt;
  logic [1:0]             pos_r, pos_nxt;
  logic                   err_r, err_nxt;

  // Groups before the gap sit at their own index; groups after the gap
  // shift in from the least significant end.
  iptp_pkg::group_t       head_r [NG];
  iptp_pkg::group_t       head_nxt [NG];
  iptp_pkg::group_t       tail_r [NG];
  iptp_pkg::group_t       tail_nxt [NG];

  // Result register.
  logic                   full_r;
  iptp_pkg::result_t      res_r, res_nxt;
  logic                   load_res;

  // Close-group request produced by the parse step.
  logic                   close_en;
  logic                   close_tail;
  logic [CW-1:0]          close_idx;
  iptp_pkg::group_t       close_val;

  // A final character waits while an untaken result sits in the register.
  assign q_take   = q_valid && (!q_item.last || !full_r || pop);
  assign load_res = q_take && q_item.last;
  assign empty    = !full_r;
  assign res      = res_r;

  // Parse step for one character.
  always_comb begin
    cnt_nxt    = cnt_r;
    gap_nxt    = gap_r;
    gidx_nxt   = gidx_r;
    acc_nxt    = acc_r;
    dcnt_nxt   = dcnt_r;
    pcol_nxt   = pcol_r;
    pos_nxt    = pos_r;
    err_nxt    = err_r;
    close_en   = 1'b0;
    close_tail = gap_r;
    close_idx  = cnt_r;
    close_val  = acc_r;

    if (!err_r) begin
      case (q_item.cls)
        iptp_pkg::CLS_COLON: begin
          if (pos_r == 2'd0) begin
            pcol_nxt = 1'b1;
          end else if (pcol_r) begin
            if (gap_r) begin
              err_nxt = 1'b1;
            end else begin
              gap_nxt  = 1'b1;
              gidx_nxt = cnt_r;
            end
          end else begin
            if (q_item.last) begin
              err_nxt = 1'b1;
            end else if (cnt_r >= FULL_CNT) begin
              err_nxt  = 1'b1;
              acc_nxt  = '0;
              dcnt_nxt = '0;
            end else begin
              close_en = 1'b1;
              cnt_nxt  = CW'(cnt_r + 1'b1);
              acc_nxt  = '0;
              dcnt_nxt = '0;
            end
            pcol_nxt = 1'b1;
          end
        end
        iptp_pkg::CLS_HEX: begin
          if ((pos_r == 2'd1 && pcol_r) || dcnt_r >= MAX_DIG) begin
            err_nxt = 1'b1;
          end else begin
            acc_nxt  = {acc_r[iptp_pkg::GROUP_W-iptp_pkg::NIBBLE_W-1:0], q_item.nibble};
            dcnt_nxt = DW'(dcnt_r + 1'b1);
            pcol_nxt = 1'b0;
          end
        end
        default: begin
          err_nxt = 1'b1;
        end
      endcase
    end

    if (!q_item.last) begin
      if (pos_r < 2'd2) begin
        pos_nxt = 2'(pos_r + 1'b1);
      end
    end else if (!err_nxt) begin
      // End of string: close the open group and check the group count.
      if (pos_r == 2'd0) begin
        err_nxt = 1'b1;
      end else begin
        if (!pcol_nxt) begin
          close_tail = gap_nxt;
          close_idx  = cnt_nxt;
          close_val  = acc_nxt;
          if (cnt_nxt >= FULL_CNT) begin
            err_nxt = 1'b1;
          end else begin
            close_en = 1'b1;
            cnt_nxt  = CW'(cnt_nxt + 1'b1);
          end
        end
        if (!err_nxt) begin
          if (cnt_nxt < FULL_CNT && !gap_nxt) begin
            err_nxt = 1'b1;
          end else if (cnt_nxt >= FULL_CNT && gap_nxt) begin
            err_nxt = 1'b1;
          end
        end
      end
    end
  end

  // Group storage updates from the close request.
  always_comb begin
    for (int i = 0; i < NG; i++) begin
      head_nxt[i] = head_r[i];
      if (close_en && !close_tail && close_idx == CW'(i)) begin
        head_nxt[i] = close_val;
      end
    end
    for (int i = 0; i < NG; i++) begin
      tail_nxt[i] = tail_r[i];
    end
    if (close_en && close_tail) begin
      for (int i = 0; i < NG - 1; i++) begin
        tail_nxt[i] = tail_r[i+1];
      end
      tail_nxt[NG-1] = close_val;
    end
  end

  // Expand the address: head groups, then zeros, then tail groups.
  always_comb begin
    logic [CW-1:0] g;
    logic [CW-1:0] t;
    g = gap_nxt ? gidx_nxt : cnt_nxt;
    t = gap_nxt ? CW'(cnt_nxt - gidx_nxt) : '0;
    res_nxt.valid = !err_nxt;
    for (int i = 0; i < NG; i++) begin
      res_nxt.grp[NG-1-i] = '0;
      if (!err_nxt) begin
        if (CW'(i) < g) begin
          res_nxt.grp[NG-1-i] = head_nxt[i];
        end else if (({1'b0, CW'(i)} + {1'b0, t}) >= (CW+1)'(NG)) begin
          res_nxt.grp[NG-1-i] = tail_nxt[i];
        end
      end
    end
  end

  // Control registers; the parse state returns to reset after a final character.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      gap_r  <= 1'b0;
      gidx_r <= '0;
      acc_r  <= '0;
      dcnt_r <= '0;
      pcol_r <= 1'b0;
      pos_r  <= '0;
      err_r  <= 1'b0;
      full_r <= 1'b0;
    end else begin
      if (q_take) begin
        if (q_item.last) begin
          cnt_r  <= '0;
          gap_r  <= 1'b0;
          gidx_r <= '0;
          acc_r  <= '0;
          dcnt_r <= '0;
          pcol_r <= 1'b0;
          pos_r  <= '0;
          err_r  <= 1'b0;
        end else begin
          cnt_r  <= cnt_nxt;
          gap_r  <= gap_nxt;
          gidx_r <= gidx_nxt;
          acc_r  <= acc_nxt;
          dcnt_r <= dcnt_nxt;
          pcol_r <= pcol_nxt;
          pos_r  <= pos_nxt;
          err_r  <= err_nxt;
        end
      end
      if (load_res) begin
        full_r <= 1'b1;
      end else if (pop) begin
        full_r <= 1'b0;
      end
    end
  end

  // Group storage and result payload need no reset.
  always_ff @(posedge clk) begin
    if (q_take) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
    if (load_res) begin
      res_r <= res_nxt;
    end
  end

  // The group count never passes eight.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("group count beyond eight");

  // The gap never sits past the groups stored so far.
  a_gap_idx: assert property (@(posedge clk) disable iff (!rst_n)
    gap_r |-> (gidx_r <= cnt_r))
    else $error("gap index beyond group count");

  // A final character leaves the parse state clear.
  a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (q_take && q_item.last) |=> (!err_r && cnt_r == '0 && !gap_r && pos_r == 2'd0))
    else $error("parse state not cleared after final character");

  // An invalid result carries all-zero groups.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (full_r && !res_r.valid) |-> (res_r.grp == '0))
    else $error("invalid result with nonzero groups");

  // A waiting result is never overwritten before its transfer.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (full_r && !pop) |=> (full_r && $stable(res_r)))
    else $error("waiting result overwritten");

endmodule
